// ----- hw/rtl/rti_pkg.sv -----
`timescale 1ns / 1ps
// Shared widths, register indexes and constants for the ray/triangle core.
// No dependencies; used by the core and its port checker.

package rti_pkg;

    localparam int CRD_W     = 32;   // vertex and origin coordinate
    localparam int DIR_W     = 18;   // direction component
    localparam int EPS_W     = 41;   // determinant threshold
    localparam int DIF_W     = 33;   // edge and origin offset
    localparam int PA_W      = 51;   // dir * edge
    localparam int P_W       = 52;   // pvec component
    localparam int QA_W      = 66;   // offset * edge
    localparam int Q_W       = 67;   // qvec component
    localparam int PLO_W     = 26;   // low split of pvec
    localparam int QLO_W     = 34;   // low split of qvec
    localparam int DL_W      = 60;
    localparam int DH_W      = 59;
    localparam int VL_W      = 53;
    localparam int VH_W      = 51;
    localparam int TL_W      = 68;
    localparam int TH_W      = 66;
    localparam int C_W       = 86;   // one dot-product term
    localparam int TC_W      = 101;  // one distance term
    localparam int SUM_W     = 88;   // det, u and v numerators
    localparam int TT_W      = 104;  // distance numerator
    localparam int DIV_STEPS = 32;
    localparam int FRAC_BITS = 16;
    localparam int UV_FRAC   = 16;
    localparam int U_W       = 17;

    localparam int CFG_AW    = 3;
    localparam int CFG_DW    = 41;
    localparam int IN_W      = 288;
    localparam int OUT_W     = 72;
    localparam int DIST_LSB  = 0;
    localparam int U_LSB     = 32;
    localparam int V_LSB     = 49;

    localparam int PRE_STAGES = 9;
    localparam int NUM_STAGES = PRE_STAGES + DIV_STEPS + 1;

    localparam logic [EPS_W-1:0] EPS_RESET = 41'd28147497671;
    localparam logic [DIR_W-1:0] DIR_ONE   = 18'd65536;
    localparam logic [CRD_W-1:0] DIST_MAX  = 32'h7FFF_FFFF;
    localparam logic [CRD_W-1:0] DIST_MIN  = 32'h8000_0000;
    localparam logic [U_W:0]     UV_ONE    = 18'h10000;

    typedef enum logic [CFG_AW-1:0] {
        REG_ORG_X = 3'd0,
        REG_ORG_Y = 3'd1,
        REG_ORG_Z = 3'd2,
        REG_DIR_X = 3'd3,
        REG_DIR_Y = 3'd4,
        REG_DIR_Z = 3'd5,
        REG_EPS   = 3'd6
    } cfg_reg_t;

endpackage

// ----- hw/rtl/ray_triangle_intersect_core.sv -----
`timescale 1ns / 1ps
// Streaming two-sided ray/triangle test against one configured ray.
// Depends on rti_pkg.

// Takes one triangle per clock while the output is not stalled and returns one
// result word per triangle, in order:
// nine stages form edges, cross and dot products (wide products split in two
// halves), the determinant flip and the range checks, then a 32-stage
// restoring divider produces t, u and v one quotient bit per stage, and an
// output register saturates t and clears misses. A stall at the output
// backs up stage by stage, so empty stages keep filling meanwhile.

module ray_triangle_intersect_core
    import rti_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_AW-1:0] cfg_addr,
    input  logic [CFG_DW-1:0] cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    // a_x, a_y, a_z, b_x, b_y, b_z, c_x, c_y, c_z (32 bits each)
    input  logic [IN_W-1:0]   s_axis_tdata,
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    // hit_distance (32), bary_u (17), bary_v (17), zero fill (6)
    output logic [OUT_W-1:0]  m_axis_tdata,
    // hit
    output logic              m_axis_tuser
);

    localparam int NS = NUM_STAGES;
    localparam int DB = PRE_STAGES;

    logic signed [CRD_W-1:0] org_reg [3];
    logic signed [DIR_W-1:0] dir_reg [3];
    logic [EPS_W-1:0]        eps_reg;

    logic [NS-1:0] vld_reg;
    logic [NS-1:0] hold;
    logic [NS-1:0] ld;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            org_reg[0] <= '0;
            org_reg[1] <= '0;
            org_reg[2] <= '0;
            dir_reg[0] <= '0;
            dir_reg[1] <= '0;
            dir_reg[2] <= DIR_ONE;
            eps_reg    <= EPS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_addr))
                REG_ORG_X: org_reg[0] <= cfg_data[CRD_W-1:0];
                REG_ORG_Y: org_reg[1] <= cfg_data[CRD_W-1:0];
                REG_ORG_Z: org_reg[2] <= cfg_data[CRD_W-1:0];
                REG_DIR_X: dir_reg[0] <= cfg_data[DIR_W-1:0];
                REG_DIR_Y: dir_reg[1] <= cfg_data[DIR_W-1:0];
                REG_DIR_Z: dir_reg[2] <= cfg_data[DIR_W-1:0];
                REG_EPS:   eps_reg    <= cfg_data[EPS_W-1:0];
                default:   eps_reg    <= eps_reg;
            endcase
        end
    end

    // stall chain: a stage holds when it is full and the next one holds
    always_comb
    begin
        hold[NS-1] = vld_reg[NS-1] && !m_axis_tready;
        for (int k = NS - 2; k >= 0; k--)
        begin
            hold[k] = vld_reg[k] && hold[k+1];
        end
        ld = ~hold;
    end

    assign s_axis_tready = ld[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            if (ld[0])
            begin
                vld_reg[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NS; k++)
            begin
                if (ld[k])
                begin
                    vld_reg[k] <= vld_reg[k-1];
                end
            end
        end
    end

    // stage 0: edges and origin offset
    logic signed [DIF_W-1:0] e1_s0_reg [3];
    logic signed [DIF_W-1:0] e2_s0_reg [3];
    logic signed [DIF_W-1:0] s_s0_reg  [3];

    always_ff @(posedge clk)
    begin
        if (ld[0])
        begin
            for (int i = 0; i < 3; i++)
            begin
                e1_s0_reg[i] <= DIF_W'($signed(s_axis_tdata[CRD_W*(3+i) +: CRD_W]))
                              - DIF_W'($signed(s_axis_tdata[CRD_W*i +: CRD_W]));
                e2_s0_reg[i] <= DIF_W'($signed(s_axis_tdata[CRD_W*(6+i) +: CRD_W]))
                              - DIF_W'($signed(s_axis_tdata[CRD_W*i +: CRD_W]));
                s_s0_reg[i]  <= DIF_W'(org_reg[i])
                              - DIF_W'($signed(s_axis_tdata[CRD_W*i +: CRD_W]));
            end
        end
    end

    // stage 1: cross-product terms; stage 2: pvec and qvec
    logic signed [PA_W-1:0]  pa_s1_reg [3];
    logic signed [PA_W-1:0]  pb_s1_reg [3];
    logic signed [QA_W-1:0]  qa_s1_reg [3];
    logic signed [QA_W-1:0]  qb_s1_reg [3];
    logic signed [DIF_W-1:0] e1_s1_reg [3];
    logic signed [DIF_W-1:0] e2_s1_reg [3];
    logic signed [DIF_W-1:0] s_s1_reg  [3];
    logic signed [P_W-1:0]   p_s2_reg  [3];
    logic signed [Q_W-1:0]   q_s2_reg  [3];
    logic signed [DIF_W-1:0] e1_s2_reg [3];
    logic signed [DIF_W-1:0] e2_s2_reg [3];
    logic signed [DIF_W-1:0] s_s2_reg  [3];

    // stage 3: split partial products; stage 4: per-component terms
    logic signed [DL_W-1:0]  dl_s3_reg [3];
    logic signed [DH_W-1:0]  dh_s3_reg [3];
    logic signed [DL_W-1:0]  ul_s3_reg [3];
    logic signed [DH_W-1:0]  uh_s3_reg [3];
    logic signed [VL_W-1:0]  vl_s3_reg [3];
    logic signed [VH_W-1:0]  vh_s3_reg [3];
    logic signed [TL_W-1:0]  tl_s3_reg [3];
    logic signed [TH_W-1:0]  th_s3_reg [3];
    logic signed [C_W-1:0]   dc_s4_reg [3];
    logic signed [C_W-1:0]   uc_s4_reg [3];
    logic signed [C_W-1:0]   vc_s4_reg [3];
    logic signed [TC_W-1:0]  tc_s4_reg [3];

    for (genvar i = 0; i < 3; i++)
    begin : g_comp
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        logic signed [PLO_W:0]       plo;
        logic signed [P_W-PLO_W-1:0] phi;
        logic signed [QLO_W:0]       qlo;
        logic signed [Q_W-QLO_W-1:0] qhi;

        assign plo = $signed({1'b0, p_s2_reg[i][PLO_W-1:0]});
        assign phi = $signed(p_s2_reg[i][P_W-1:PLO_W]);
        assign qlo = $signed({1'b0, q_s2_reg[i][QLO_W-1:0]});
        assign qhi = $signed(q_s2_reg[i][Q_W-1:QLO_W]);

        always_ff @(posedge clk)
        begin
            if (ld[1])
            begin
                pa_s1_reg[i] <= PA_W'(dir_reg[J] * e2_s0_reg[K]);
                pb_s1_reg[i] <= PA_W'(dir_reg[K] * e2_s0_reg[J]);
                qa_s1_reg[i] <= QA_W'(s_s0_reg[J] * e1_s0_reg[K]);
                qb_s1_reg[i] <= QA_W'(s_s0_reg[K] * e1_s0_reg[J]);
                e1_s1_reg[i] <= e1_s0_reg[i];
                e2_s1_reg[i] <= e2_s0_reg[i];
                s_s1_reg[i]  <= s_s0_reg[i];
            end
            if (ld[2])
            begin
                p_s2_reg[i]  <= P_W'(pa_s1_reg[i]) - P_W'(pb_s1_reg[i]);
                q_s2_reg[i]  <= Q_W'(qa_s1_reg[i]) - Q_W'(qb_s1_reg[i]);
                e1_s2_reg[i] <= e1_s1_reg[i];
                e2_s2_reg[i] <= e2_s1_reg[i];
                s_s2_reg[i]  <= s_s1_reg[i];
            end
            if (ld[3])
            begin
                dl_s3_reg[i] <= DL_W'(e1_s2_reg[i] * plo);
                dh_s3_reg[i] <= DH_W'(e1_s2_reg[i] * phi);
                ul_s3_reg[i] <= DL_W'(s_s2_reg[i] * plo);
                uh_s3_reg[i] <= DH_W'(s_s2_reg[i] * phi);
                vl_s3_reg[i] <= VL_W'(dir_reg[i] * qlo);
                vh_s3_reg[i] <= VH_W'(dir_reg[i] * qhi);
                tl_s3_reg[i] <= TL_W'(e2_s2_reg[i] * qlo);
                th_s3_reg[i] <= TH_W'(e2_s2_reg[i] * qhi);
            end
            if (ld[4])
            begin
                dc_s4_reg[i] <= (C_W'(dh_s3_reg[i]) <<< PLO_W) + C_W'(dl_s3_reg[i]);
                uc_s4_reg[i] <= (C_W'(uh_s3_reg[i]) <<< PLO_W) + C_W'(ul_s3_reg[i]);
                vc_s4_reg[i] <= (C_W'(vh_s3_reg[i]) <<< QLO_W) + C_W'(vl_s3_reg[i]);
                tc_s4_reg[i] <= (TC_W'(th_s3_reg[i]) <<< QLO_W) + TC_W'(tl_s3_reg[i]);
            end
        end
    end

    // stage 5: dot products; stage 6: flip on non-positive determinant
    logic signed [SUM_W-1:0] det_s5_reg;
    logic signed [SUM_W-1:0] uu_s5_reg;
    logic signed [SUM_W-1:0] vv_s5_reg;
    logic signed [TT_W-1:0]  tt_s5_reg;
    logic [SUM_W-1:0]        det_s6_reg;
    logic signed [SUM_W-1:0] uu_s6_reg;
    logic signed [SUM_W-1:0] vv_s6_reg;
    logic signed [TT_W-1:0]  tt_s6_reg;
    logic                    flip;

    assign flip = det_s5_reg[SUM_W-1] || (det_s5_reg == '0);

    always_ff @(posedge clk)
    begin
        if (ld[5])
        begin
            det_s5_reg <= SUM_W'(dc_s4_reg[0]) + SUM_W'(dc_s4_reg[1]) + SUM_W'(dc_s4_reg[2]);
            uu_s5_reg  <= SUM_W'(uc_s4_reg[0]) + SUM_W'(uc_s4_reg[1]) + SUM_W'(uc_s4_reg[2]);
            vv_s5_reg  <= SUM_W'(vc_s4_reg[0]) + SUM_W'(vc_s4_reg[1]) + SUM_W'(vc_s4_reg[2]);
            tt_s5_reg  <= TT_W'(tc_s4_reg[0]) + TT_W'(tc_s4_reg[1]) + TT_W'(tc_s4_reg[2]);
        end
        if (ld[6])
        begin
            det_s6_reg <= flip ? SUM_W'(-det_s5_reg) : SUM_W'(det_s5_reg);
            uu_s6_reg  <= flip ? -uu_s5_reg : uu_s5_reg;
            vv_s6_reg  <= flip ? -vv_s5_reg : vv_s5_reg;
            tt_s6_reg  <= flip ? -tt_s5_reg : tt_s5_reg;
        end
    end

    // stage 7: threshold and u checks; stage 8: v checks, overflow, divider seed
    logic                    rej_s7_reg;
    logic [SUM_W-1:0]        det_s7_reg;
    logic signed [SUM_W-1:0] uu_s7_reg;
    logic signed [SUM_W-1:0] vv_s7_reg;
    logic signed [SUM_W:0]   sum_s7_reg;
    logic                    tneg_s7_reg;
    logic [TT_W-1:0]         tabs_s7_reg;

    logic                    rej_s8_reg;
    logic                    ovf_s8_reg;
    logic                    tneg_s8_reg;
    logic [SUM_W-1:0]        det_s8_reg;
    logic [SUM_W-1:0]        rem_s8_reg  [3];
    logic [DIV_STEPS-1:0]    bits_s8_reg [3];

    always_ff @(posedge clk)
    begin
        if (ld[7])
        begin
            rej_s7_reg  <= (det_s6_reg == '0)
                        || (det_s6_reg < SUM_W'(eps_reg))
                        || uu_s6_reg[SUM_W-1]
                        || ($signed({1'b0, det_s6_reg}) < (SUM_W+1)'(uu_s6_reg));
            det_s7_reg  <= det_s6_reg;
            uu_s7_reg   <= uu_s6_reg;
            vv_s7_reg   <= vv_s6_reg;
            sum_s7_reg  <= (SUM_W+1)'(uu_s6_reg) + (SUM_W+1)'(vv_s6_reg);
            tneg_s7_reg <= tt_s6_reg[TT_W-1];
            tabs_s7_reg <= tt_s6_reg[TT_W-1] ? TT_W'(-tt_s6_reg) : TT_W'(tt_s6_reg);
        end
        if (ld[8])
        begin
            rej_s8_reg     <= rej_s7_reg || vv_s7_reg[SUM_W-1]
                           || ($signed({1'b0, det_s7_reg}) < sum_s7_reg);
            ovf_s8_reg     <= (tabs_s7_reg >> (DIV_STEPS - FRAC_BITS)) >= TT_W'(det_s7_reg);
            tneg_s8_reg    <= tneg_s7_reg;
            det_s8_reg     <= det_s7_reg;
            rem_s8_reg[0]  <= SUM_W'(tabs_s7_reg >> (DIV_STEPS - FRAC_BITS));
            bits_s8_reg[0] <= DIV_STEPS'(tabs_s7_reg << FRAC_BITS);
            rem_s8_reg[1]  <= SUM_W'(uu_s7_reg >>> (DIV_STEPS - UV_FRAC));
            bits_s8_reg[1] <= DIV_STEPS'(uu_s7_reg << UV_FRAC);
            rem_s8_reg[2]  <= SUM_W'(vv_s7_reg >>> (DIV_STEPS - UV_FRAC));
            bits_s8_reg[2] <= DIV_STEPS'(vv_s7_reg << UV_FRAC);
        end
    end

    // divider: one restoring step per stage for t, u and v side by side
    logic [SUM_W-1:0]     rem_reg  [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] bits_reg [DIV_STEPS][3];
    logic [DIV_STEPS-1:0] quo_reg  [DIV_STEPS][3];
    logic [SUM_W-1:0]     ddet_reg [DIV_STEPS];
    logic                 drej_reg [DIV_STEPS];
    logic                 dovf_reg [DIV_STEPS];
    logic                 dneg_reg [DIV_STEPS];

    for (genvar k = 0; k < DIV_STEPS; k++)
    begin : g_div
        logic [SUM_W-1:0]     prem  [3];
        logic [DIV_STEPS-1:0] pbits [3];
        logic [DIV_STEPS-1:0] pquo  [3];
        logic [SUM_W-1:0]     pdet;
        logic                 prej;
        logic                 povf;
        logic                 pneg;
        logic [SUM_W:0]       trial [3];
        logic [SUM_W:0]       diff  [3];
        logic [2:0]           ge;

        if (k == 0)
        begin : g_first
            assign prem  = rem_s8_reg;
            assign pbits = bits_s8_reg;
            assign pquo  = '{default: '0};
            assign pdet  = det_s8_reg;
            assign prej  = rej_s8_reg;
            assign povf  = ovf_s8_reg;
            assign pneg  = tneg_s8_reg;
        end
        else
        begin : g_next
            assign prem  = rem_reg[k-1];
            assign pbits = bits_reg[k-1];
            assign pquo  = quo_reg[k-1];
            assign pdet  = ddet_reg[k-1];
            assign prej  = drej_reg[k-1];
            assign povf  = dovf_reg[k-1];
            assign pneg  = dneg_reg[k-1];
        end

        always_comb
        begin
            for (int j = 0; j < 3; j++)
            begin
                trial[j] = {prem[j], pbits[j][DIV_STEPS-1]};
                diff[j]  = trial[j] - {1'b0, pdet};
                ge[j]    = trial[j] >= {1'b0, pdet};
            end
        end

        always_ff @(posedge clk)
        begin
            if (ld[DB+k])
            begin
                for (int j = 0; j < 3; j++)
                begin
                    rem_reg[k][j]  <= ge[j] ? diff[j][SUM_W-1:0] : trial[j][SUM_W-1:0];
                    bits_reg[k][j] <= {pbits[j][DIV_STEPS-2:0], 1'b0};
                    quo_reg[k][j]  <= {pquo[j][DIV_STEPS-2:0], ge[j]};
                end
                ddet_reg[k] <= pdet;
                drej_reg[k] <= prej;
                dovf_reg[k] <= povf;
                dneg_reg[k] <= pneg;
            end
        end
    end

    // output: saturate t, clear misses
    logic                 hit_reg;
    logic [CRD_W-1:0]     dist_reg;
    logic [U_W-1:0]       u_reg;
    logic [U_W-1:0]       v_reg;
    logic [CRD_W-1:0]     dist_next;
    logic [DIV_STEPS-1:0] qt;

    assign qt = quo_reg[DIV_STEPS-1][0];

    always_comb
    begin
        if (dovf_reg[DIV_STEPS-1])
        begin
            dist_next = dneg_reg[DIV_STEPS-1] ? DIST_MIN : DIST_MAX;
        end
        else if (!dneg_reg[DIV_STEPS-1])
        begin
            dist_next = qt[DIV_STEPS-1] ? DIST_MAX : qt;
        end
        else
        begin
            dist_next = (qt > DIST_MIN) ? DIST_MIN : CRD_W'(-qt);
        end
    end

    always_ff @(posedge clk)
    begin
        if (ld[NS-1])
        begin
            hit_reg  <= !drej_reg[DIV_STEPS-1];
            dist_reg <= drej_reg[DIV_STEPS-1] ? '0 : dist_next;
            u_reg    <= drej_reg[DIV_STEPS-1] ? '0 : quo_reg[DIV_STEPS-1][1][U_W-1:0];
            v_reg    <= drej_reg[DIV_STEPS-1] ? '0 : quo_reg[DIV_STEPS-1][2][U_W-1:0];
        end
    end

    assign m_axis_tvalid = vld_reg[NS-1];
    assign m_axis_tuser  = hit_reg;
    assign m_axis_tdata  = {(OUT_W - CRD_W - 2 * U_W)'(0), v_reg, u_reg, dist_reg};

endmodule

// ----- hw/rtl/rti_chk.sv -----
`timescale 1ns / 1ps
// Port-level checker for ray_triangle_intersect_core, attached by bind.
// Depends on rti_pkg.

module rti_chk
    import rti_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              s_axis_tready,
    input logic              m_axis_tvalid,
    input logic              m_axis_tready,
    input logic [OUT_W-1:0]  m_axis_tdata,
    input logic              m_axis_tuser
);

    a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata == '0))
        else $error("miss word carries nonzero payload");

    a_bary_sum: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser) |->
        (({1'b0, m_axis_tdata[U_LSB +: U_W]} + {1'b0, m_axis_tdata[V_LSB +: U_W]}) <= UV_ONE))
        else $error("u plus v exceeds one on a hit");

    a_valid_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
        else $error("output word dropped while stalled");

    a_data_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> ($stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("output word changed while stalled");

    a_ready_free: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tready |-> s_axis_tready)
        else $error("input stalled while output is free");

endmodule

bind ray_triangle_intersect_core rti_chk u_rti_chk (.*);
